/* src/morse_character_keyer_defines.svh */
// Assertion macros used by the keyer top level.
`ifndef MORSE_CHARACTER_KEYER_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MCK_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mck_pkg.sv */
// Shared constants, types and the Morse pattern lookup for the keyer.
`default_nettype none

package mck_pkg;

  localparam int RegWidth             = 24;
  localparam int DurationWidthDefault = 24;
  localparam int CharWidth            = 8;
  localparam int CountWidth           = 3;
  localparam int BitsWidth            = 5;
  localparam int NumPatterns          = 36;
  localparam int SelWidth             = 6;
  localparam int FifoDepth            = 2;

  localparam logic [RegWidth-1:0] DotReset  = 24'd200000;
  localparam logic [RegWidth-1:0] DashReset = 24'd600000;
  localparam logic [RegWidth-1:0] GapReset  = 24'd600000;

  localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
  localparam logic [CharWidth-1:0] CharLowZ  = 8'h7a;
  localparam logic [CharWidth-1:0] CharZero  = 8'h30;
  localparam logic [CharWidth-1:0] CharNine  = 8'h39;
  localparam logic [SelWidth-1:0]  DigitBase = 6'd26;

  typedef enum logic [1:0] {
    RegDot  = 2'd0,
    RegDash = 2'd1,
    RegGap  = 2'd2
  } reg_idx_e;

  // Symbol counts and patterns (1 = dash), a-z then 0-9, first symbol in the
  // highest used bit.
  localparam logic [CountWidth-1:0] SymCount [NumPatterns] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };
  localparam logic [BitsWidth-1:0] SymBits [NumPatterns] = '{
    5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7, 5'd5, 5'd4,
    5'd3, 5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1, 5'd1, 5'd1, 5'd3, 5'd9,
    5'd11, 5'd12,
    5'd31, 5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30
  };

  // One classified character; bits are left-aligned so the current symbol
  // always sits in the top bit.
  typedef struct packed {
    logic                  unsup;
    logic [CountWidth-1:0] count;
    logic [BitsWidth-1:0]  bits;
  } pattern_t;

  function automatic pattern_t classify(input logic [CharWidth-1:0] c);
    pattern_t             p;
    logic [SelWidth-1:0]  sel;
    logic                 is_letter;
    logic                 is_digit;
    logic [BitsWidth-1:0] raw;
    p         = '0;
    is_letter = (c >= CharLowA) && (c <= CharLowZ);
    is_digit  = (c >= CharZero) && (c <= CharNine);
    if (is_letter) begin
      sel = SelWidth'(c - CharLowA);
    end else begin
      sel = DigitBase + SelWidth'(c - CharZero);
    end
    if (is_letter || is_digit) begin
      raw     = SymBits[sel];
      p.count = SymCount[sel];
      p.bits  = raw << (3'(BitsWidth) - p.count);
    end else begin
      p.unsup = 1'b1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

/* src/mck_front.sv */
// Front end: takes characters and classifies them into Morse patterns.
`default_nettype none

module mck_front (
  input  logic                               in_valid_i,
  input  logic [mck_pkg::CharWidth-1:0]      character_i,
  input  logic                               queue_full_i,
  output logic                               in_stall_o,
  output logic                               push_o,
  output mck_pkg::pattern_t                  push_data_o
);
  import mck_pkg::*;

  assign in_stall_o  = queue_full_i;
  assign push_o      = in_valid_i && !queue_full_i;
  assign push_data_o = classify(character_i);

endmodule

`default_nettype wire

/* src/mck_fifo.sv */
// Short pattern queue between front and back end.
`default_nettype none

module mck_fifo #(
  parameter int Depth = mck_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mck_pkg::pattern_t push_data_i,
  input  logic              pop_i,
  output mck_pkg::pattern_t pop_data_o,
  output logic              empty_o,
  output logic              full_o
);
  import mck_pkg::*;

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  pattern_t              entries_q [Depth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q,  count_d;

  function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] p);
    return (p == PtrWidth'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CntWidth'(Depth));
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? bump(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* src/mck_back.sv */
// Back end: plays a pattern out as LED segments, one per cycle while the output is not stalled.
`default_nettype none

module mck_back #(
  parameter int DurationWidth = mck_pkg::DurationWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mck_pkg::RegWidth-1:0] dot_length_i,
  input  logic [mck_pkg::RegWidth-1:0] dash_length_i,
  input  logic [mck_pkg::RegWidth-1:0] char_gap_length_i,
  input  mck_pkg::pattern_t            pop_data_i,
  input  logic                         queue_empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         led_level_o,
  output logic [DurationWidth-1:0]     duration_o,
  output logic                         last_segment_o
);
  import mck_pkg::*;

  localparam int ExtWidth = (DurationWidth > RegWidth) ? DurationWidth : RegWidth;
  localparam logic [ExtWidth-1:0] DurMax = ExtWidth'({DurationWidth{1'b1}});

  typedef enum logic [1:0] {
    Idle,
    SendGap,
    SendMark,
    SendSpace
  } state_e;

  state_e                 state_q, state_d;
  logic [CountWidth-1:0]  cnt_q, cnt_d;
  logic [BitsWidth-1:0]   bits_q, bits_d;
  logic                   valid_q, valid_d;
  logic                   led_q, led_d;
  logic [DurationWidth-1:0] dur_q, dur_d;
  logic                   last_q, last_d;

  logic                   out_free;
  logic                   finishing;
  logic [DurationWidth-1:0] dot_fit, dash_fit, gap_fit;

  // Saturate a register value into the duration field.
  function automatic logic [DurationWidth-1:0] fit(input logic [RegWidth-1:0] v);
    logic [ExtWidth-1:0] ext;
    ext = ExtWidth'(v);
    return (ext > DurMax) ? DurationWidth'(DurMax) : DurationWidth'(ext);
  endfunction

  assign dot_fit  = fit(dot_length_i);
  assign dash_fit = fit(dash_length_i);
  assign gap_fit  = fit(char_gap_length_i);

  assign out_free  = !valid_q || !out_stall_i;
  assign finishing = out_free &&
                     ((state_q == SendGap) ||
                      ((state_q == SendSpace) && (cnt_q == CountWidth'(1))));
  assign pop_o     = !queue_empty_i && ((state_q == Idle) || finishing);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bits_d  = bits_q;
    valid_d = valid_q;
    led_d   = led_q;
    dur_d   = dur_q;
    last_d  = last_q;
    if (out_free) begin
      unique case (state_q)
        Idle: begin
          valid_d = 1'b0;
        end
        SendGap: begin
          valid_d = 1'b1;
          led_d   = 1'b0;
          dur_d   = gap_fit;
          last_d  = 1'b1;
          state_d = Idle;
        end
        SendMark: begin
          valid_d = 1'b1;
          led_d   = 1'b1;
          dur_d   = bits_q[BitsWidth-1] ? dash_fit : dot_fit;
          last_d  = 1'b0;
          state_d = SendSpace;
        end
        SendSpace: begin
          valid_d = 1'b1;
          led_d   = 1'b0;
          dur_d   = dot_fit;
          last_d  = (cnt_q == CountWidth'(1));
          bits_d  = bits_q << 1;
          cnt_d   = cnt_q - 1'b1;
          state_d = (cnt_q == CountWidth'(1)) ? Idle : SendMark;
        end
        default: begin
          state_d = Idle;
        end
      endcase
    end
    if (pop_o) begin
      state_d = pop_data_i.unsup ? SendGap : SendMark;
      cnt_d   = pop_data_i.count;
      bits_d  = pop_data_i.bits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      cnt_q   <= '0;
      bits_q  <= '0;
      valid_q <= 1'b0;
      led_q   <= 1'b0;
      dur_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bits_q  <= bits_d;
      valid_q <= valid_d;
      led_q   <= led_d;
      dur_q   <= dur_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign led_level_o    = led_q;
  assign duration_o     = dur_q;
  assign last_segment_o = last_q;

endmodule

`default_nettype wire

/* src/morse_character_keyer.sv */
// Top level of the Morse character keyer: config registers, front, queue, back.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | to block  | in_valid_i / in_stall_o   | character_i
//  out     | from block| out_valid_o / out_stall_i | led_level_o, duration_o, last_segment_o
//  cfg     | to block  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A character is classified in the cycle it is taken and queued (two entries).
//  The segment emitter produces one segment per cycle unless the output stalls: a
//  letter or digit gives 2 to 10 segments (two per symbol), any other character gives one.
//  The next character is loaded in the same cycle its predecessor's last
//  segment is registered for output, so characters follow each other without bubbles.
//  Reset (async, active low) restores dot 200000, dash 600000, gap 600000 and
//  empties the queue and output register. Out stalls hold the output register
//  and back up into the queue; in_stall_o rises only when the queue is full.
//  cfg_ready_o is always high; writes to an index beyond the list are dropped.
`default_nettype none
`include "morse_character_keyer_defines.svh"

module morse_character_keyer #(
  parameter int DurationWidth = mck_pkg::DurationWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // character input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mck_pkg::CharWidth-1:0] character_i,
  // segment output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          led_level_o,
  output logic [DurationWidth-1:0]      duration_o,
  output logic                          last_segment_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [mck_pkg::RegWidth-1:0]  cfg_data_i
);
  import mck_pkg::*;

  logic [RegWidth-1:0] dot_length_q, dash_length_q, char_gap_length_q;
  logic [RegWidth-1:0] dot_length_d, dash_length_d, char_gap_length_d;

  logic     fifo_push, fifo_pop, fifo_empty, fifo_full;
  pattern_t fifo_wdata, fifo_rdata;

  // Register file: always ready, one transfer per cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    dot_length_d      = dot_length_q;
    dash_length_d     = dash_length_q;
    char_gap_length_d = char_gap_length_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegDot:  dot_length_d      = cfg_data_i;
        RegDash: dash_length_d     = cfg_data_i;
        RegGap:  char_gap_length_d = cfg_data_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_length_q      <= DotReset;
      dash_length_q     <= DashReset;
      char_gap_length_q <= GapReset;
    end else begin
      dot_length_q      <= dot_length_d;
      dash_length_q     <= dash_length_d;
      char_gap_length_q <= char_gap_length_d;
    end
  end

  mck_front u_front (
    .in_valid_i   (in_valid_i),
    .character_i  (character_i),
    .queue_full_i (fifo_full),
    .in_stall_o   (in_stall_o),
    .push_o       (fifo_push),
    .push_data_o  (fifo_wdata)
  );

  mck_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_wdata),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_rdata),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  mck_back #(
    .DurationWidth (DurationWidth)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dot_length_i      (dot_length_q),
    .dash_length_i     (dash_length_q),
    .char_gap_length_i (char_gap_length_q),
    .pop_data_i        (fifo_rdata),
    .queue_empty_i     (fifo_empty),
    .pop_o             (fifo_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .led_level_o       (led_level_o),
    .duration_o        (duration_o),
    .last_segment_o    (last_segment_o)
  );

  // A taken character is still queued in the following cycle.
  `MCK_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, in_valid_i && !in_stall_o, !fifo_empty, "accepted character missing from queue")
  // An LED-on segment is always followed by its gap, so it is never last.
  `MCK_ASSERT_NOW(a_mark_not_last, clk_i, rst_ni, out_valid_o && led_level_o, !last_segment_o, "mark segment flagged last")
  // The emitter never pops an empty queue.
  `MCK_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, fifo_pop, !fifo_empty, "pop from empty queue")

endmodule

`default_nettype wire
